>>> src/bfa_pkg.sv
// Package with the constants and types shared by the frame allocator files.
package bfa_pkg;

  localparam int NumFrames  = 4096;
  localparam int WordBits   = 64;
  localparam int NumWords   = NumFrames / WordBits;
  localparam int WordAw     = $clog2(NumWords);
  localparam int BitAw      = $clog2(WordBits);
  localparam int FrameW     = 12;
  localparam int CountW     = 13;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  typedef logic [WordBits-1:0] word_t;

endpackage

>>> src/bfa_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] frame_index;
  logic [12:0] run_length;
  modport source (output valid, command, frame_index, run_length, input ready);
  modport sink (input valid, command, frame_index, run_length, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [11:0] result_frame;
  logic [12:0] free_frames;
  modport source (output valid, success, result_frame, free_frames, input ready);
  modport sink (input valid, success, result_frame, free_frames, output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> src/bitmap_frame_allocator.sv
// Bitmap page-frame allocator: one used bit per frame, held in a 64-bit-wide word memory.
// The used bits live in a 64 x 64-bit synchronous memory. After reset every
// frame is used (a clearing pass sets all words, during which no request is
// taken). Each word visited is read in one state and evaluated in the next. A
// free reads its word when taken, writes it back, then gives its result. A
// single-frame allocation scans one word at a time from the hint, wrapping
// once, so it visits up to 128 words. A run allocation reads the map word by
// word from frame zero, tracking the current run, then reads and rewrites each
// word of the run found. A result waits in an output register; one request is
// worked on at a time, and no request is taken while a result waits.
module bitmap_frame_allocator
  import bfa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  bfa_req_if.sink   in,
  bfa_rsp_if.source out,
  bfa_cfg_if.sink   cfg
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ARD   = 4'd2;
  localparam logic [3:0] ST_AEVAL = 4'd3;
  localparam logic [3:0] ST_FEVAL = 4'd4;
  localparam logic [3:0] ST_RRD   = 4'd5;
  localparam logic [3:0] ST_REVAL = 4'd6;
  localparam logic [3:0] ST_RWR   = 4'd7;
  localparam logic [3:0] ST_RWRD  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // Word memory with registered read.
  word_t mem [NumWords];
  word_t rd_data_r;
  logic  [WordAw-1:0] rd_addr, wr_addr;
  logic  rd_en, wr_en;
  word_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  logic [3:0] state_r, state_nxt;
  logic [CountW-1:0] limit_r, hint_r, hint_nxt, count_r, count_nxt;
  logic [FrameW-1:0] fidx_r;
  logic [CountW-1:0] rlen_r;
  logic [WordAw:0] widx_r, widx_nxt;
  logic wrapped_r, wrapped_nxt;
  logic [CountW-1:0] run_r, run_nxt, start_r, start_nxt;
  logic ok_r, ok_nxt;
  logic [FrameW-1:0] res_r, res_nxt;
  logic [CountW-1:0] lim;

  assign lim = (limit_r > CountW'(NumFrames)) ? CountW'(NumFrames) : limit_r;

  // Output register.
  logic ovalid_r;
  logic [FrameW-1:0] ofr_r;
  logic [CountW-1:0] ofree_r;
  logic osucc_r;
  assign out.valid = ovalid_r;
  assign out.success = osucc_r;
  assign out.result_frame = ofr_r;
  assign out.free_frames = ofree_r;
  assign in.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign cfg.ready = 1'b1;

  // Per-word masks: bits that are free and below the limit (and at/above hint until the scan wraps).
  logic [CountW-1:0] wbase;
  word_t free_lim, free_scan;
  logic [BitAw-1:0] first_bit;
  logic any_free;
  assign wbase = {1'b0, widx_r[WordAw-1:0], {BitAw{1'b0}}};

  always_comb begin
    logic [CountW-1:0] f;
    for (int b = 0; b < WordBits; b++) begin
      f = wbase + CountW'(b);
      free_lim[b]  = ~rd_data_r[b] && (f < lim);
      free_scan[b] = free_lim[b] && (wrapped_r || f >= hint_r);
    end
    first_bit = '0;
    any_free = 1'b0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (free_scan[b]) begin
        first_bit = BitAw'(b);
        any_free = 1'b1;
      end
    end
  end

  // Run tracking across one word. Each bit works out the length of the free run
  // ending there, from the last used bit below it or from the run carried in.
  logic run_hit;
  logic [CountW-1:0] run_word, run_end;
  always_comb begin
    logic [CountW-1:0] run_at [WordBits];
    logic [BitAw:0] last_used;
    run_hit = 1'b0;
    run_end = '0;
    for (int b = 0; b < WordBits; b++) begin
      last_used = '0;
      for (int j = 0; j <= b; j++) begin
        if (!free_lim[j]) last_used = (BitAw+1)'(j + 1);
      end
      if (!free_lim[b]) run_at[b] = '0;
      else if (last_used == '0) run_at[b] = run_r + CountW'(b + 1);
      else run_at[b] = CountW'(b + 1) - CountW'(last_used);
    end
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (free_lim[b] && run_at[b] == rlen_r) begin
        run_hit = 1'b1;
        run_end = wbase + CountW'(b);
      end
    end
    run_word = run_at[WordBits-1];
  end

  // Mask for rewriting the run: bits of the current word in [start, start+run_length).
  word_t run_mask;
  always_comb begin
    logic [CountW-1:0] f;
    for (int b = 0; b < WordBits; b++) begin
      f = wbase + CountW'(b);
      run_mask[b] = (f >= start_r) && ((f - start_r) < rlen_r);
    end
  end

  logic [CountW-1:0] hint_word_frame;
  assign hint_word_frame = hint_r;

  always_comb begin
    state_nxt = state_r;
    widx_nxt = widx_r;
    wrapped_nxt = wrapped_r;
    run_nxt = run_r;
    start_nxt = start_r;
    hint_nxt = hint_r;
    count_nxt = count_r;
    ok_nxt = ok_r;
    res_nxt = res_r;
    rd_en = 1'b0;
    rd_addr = widx_r[WordAw-1:0];
    wr_en = 1'b0;
    wr_addr = widx_r[WordAw-1:0];
    wr_data = rd_data_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_data = '1;
        widx_nxt = widx_r + 1'b1;
        if (widx_r[WordAw-1:0] == WordAw'(NumWords - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in.valid && !ovalid_r) begin
          ok_nxt = 1'b0;
          res_nxt = '0;
          run_nxt = '0;
          case (in.command)
            CMD_ALLOC: begin
              wrapped_nxt = (hint_r >= lim);
              widx_nxt = (hint_r >= lim) ? '0 :
                         {1'b0, hint_word_frame[CountW-2 -: WordAw]};
              state_nxt = (lim == '0) ? ST_DONE : ST_ARD;
            end
            CMD_FREE: begin
              widx_nxt = {1'b0, in.frame_index[FrameW-1 -: WordAw]};
              rd_en = 1'b1;
              rd_addr = in.frame_index[FrameW-1 -: WordAw];
              state_nxt = ST_FEVAL;
            end
            CMD_RUN: begin
              widx_nxt = '0;
              state_nxt = (in.run_length != '0 && in.run_length <= lim) ?
                          ST_RRD : ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ARD: begin
        rd_en = 1'b1;
        state_nxt = ST_AEVAL;
      end
      ST_AEVAL: begin
        if (any_free) begin
          wr_en = 1'b1;
          wr_data = rd_data_r | (word_t'(1) << first_bit);
          ok_nxt = 1'b1;
          res_nxt = FrameW'(wbase + CountW'(first_bit));
          hint_nxt = wbase + CountW'(first_bit) + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_DONE;
        end else if (wbase + CountW'(WordBits) >= lim ||
                     widx_r[WordAw-1:0] == WordAw'(NumWords - 1)) begin
          if (wrapped_r) state_nxt = ST_DONE;
          else begin
            wrapped_nxt = 1'b1;
            widx_nxt = '0;
            state_nxt = ST_ARD;
          end
        end else begin
          widx_nxt = widx_r + 1'b1;
          state_nxt = ST_ARD;
        end
      end
      ST_FEVAL: begin
        if ({1'b0, fidx_r} < lim && rd_data_r[fidx_r[BitAw-1:0]]) begin
          wr_en = 1'b1;
          wr_data = rd_data_r & ~(word_t'(1) << fidx_r[BitAw-1:0]);
          ok_nxt = 1'b1;
          count_nxt = count_r + 1'b1;
          if ({1'b0, fidx_r} < hint_r) hint_nxt = {1'b0, fidx_r};
        end
        state_nxt = ST_DONE;
      end
      ST_RRD: begin
        rd_en = 1'b1;
        state_nxt = ST_REVAL;
      end
      ST_REVAL: begin
        run_nxt = run_word;
        if (run_hit) begin
          start_nxt = run_end + 1'b1 - rlen_r;
          ok_nxt = 1'b1;
          res_nxt = FrameW'(run_end + 1'b1 - rlen_r);
          count_nxt = count_r - rlen_r;
          widx_nxt = {1'b0, start_nxt[CountW-2 -: WordAw]};
          state_nxt = ST_RWR;
        end else if (wbase + CountW'(WordBits) >= lim ||
                     widx_r[WordAw-1:0] == WordAw'(NumWords - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          widx_nxt = widx_r + 1'b1;
          state_nxt = ST_RRD;
        end
      end
      ST_RWR: begin
        rd_en = 1'b1;
        state_nxt = ST_RWRD;
      end
      ST_RWRD: begin
        wr_en = 1'b1;
        wr_data = rd_data_r | run_mask;
        if (wbase + CountW'(WordBits) >= start_r + rlen_r) state_nxt = ST_DONE;
        else begin
          widx_nxt = widx_r + 1'b1;
          state_nxt = ST_RWR;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      widx_r <= '0;
      limit_r <= CountW'(NumFrames);
      hint_r <= '0;
      count_r <= '0;
      ovalid_r <= 1'b0;
      wrapped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      widx_r <= widx_nxt;
      wrapped_r <= wrapped_nxt;
      hint_r <= hint_nxt;
      count_r <= count_nxt;
      if (cfg.valid) limit_r <= cfg.data;
      if (state_r == ST_DONE) ovalid_r <= 1'b1;
      else if (out.ready) ovalid_r <= 1'b0;
    end
  end

  // Request capture, working values and result payload.
  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    start_r <= start_nxt;
    ok_r <= ok_nxt;
    res_r <= res_nxt;
    if (in.valid && in.ready) begin
      fidx_r <= in.frame_index;
      rlen_r <= in.run_length;
    end
    if (state_r == ST_DONE) begin
      osucc_r <= ok_r;
      ofr_r <= ok_r ? res_r : '0;
      ofree_r <= count_r;
    end
  end

endmodule

>>> src/bfa_checker.sv
// Port-level checker for the frame allocator, bound to the top level.
module bfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_success,
  input logic [11:0] out_result_frame
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A failed result reports frame zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_result_frame == 12'd0)
    else $error("failed result with nonzero frame");

  // No request is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken with result pending");

  // A request is never answered in the cycle after it is taken.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .out_success(out.success), .out_result_frame(out.result_frame)
);

>>> sim/tb.sv
// Self-checking testbench for the bitmap frame allocator: directed table then random requests.
`timescale 1ns / 100ps
module tb;
  import bfa_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] frame_index;
    logic [12:0] run_length;
  } request_t;

  typedef struct packed {
    logic        success;
    logic [11:0] result_frame;
    logic [12:0] free_frames;
  } outcome_t;

  // One row of the directed table: a request, or a limit write when is_cfg is set.
  typedef struct {
    bit          is_cfg;
    logic [12:0] cfg_value;
    request_t    req;
    bit          typed;
    outcome_t    want;
  } row_t;

  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int CycleLimit = 2000000;

  logic clk;
  logic rst_n;
  bfa_req_if req_ch();
  bfa_rsp_if rsp_ch();
  bfa_cfg_if cfg_ch();

  bitmap_frame_allocator uut (
    .clk  (clk),
    .rst_n(rst_n),
    .in   (req_ch.sink),
    .out  (rsp_ch.source),
    .cfg  (cfg_ch.sink)
  );

  // Predictor state.
  bit          pred_used [NumFrames];
  int unsigned pred_hint;
  int unsigned pred_free;
  int unsigned pred_limit;

  outcome_t    pending_outcomes[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int unsigned cycles;
  row_t        directed[$];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter with a generous limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic void predict_reset();
    foreach (pred_used[i]) pred_used[i] = 1'b1;
    pred_hint = 0;
    pred_free = 0;
    pred_limit = NumFrames;
  endfunction

  function automatic outcome_t predict_request(request_t r);
    outcome_t o;
    int unsigned lim;
    int unsigned hit;
    int unsigned run;
    bit found;
    lim = (pred_limit > NumFrames) ? NumFrames : pred_limit;
    o = '0;
    found = 0;
    hit = 0;
    case (r.command)
      CMD_ALLOC: begin
        for (int unsigned i = pred_hint; i < lim && !found; i++)
          if (!pred_used[i]) begin found = 1; hit = i; end
        for (int unsigned i = 0; i < lim && !found; i++)
          if (!pred_used[i]) begin found = 1; hit = i; end
        if (found) begin
          pred_used[hit] = 1'b1;
          pred_free = (pred_free - 1) & 13'h1fff;
          pred_hint = (hit + 1) & 13'h1fff;
          o.success = 1'b1;
          o.result_frame = hit[11:0];
        end
      end
      CMD_FREE: begin
        if (r.frame_index < lim && pred_used[r.frame_index]) begin
          pred_used[r.frame_index] = 1'b0;
          pred_free = (pred_free + 1) & 13'h1fff;
          if (r.frame_index < pred_hint) pred_hint = r.frame_index;
          o.success = 1'b1;
        end
      end
      CMD_RUN: begin
        if (r.run_length != 0 && r.run_length <= lim) begin
          run = 0;
          for (int unsigned i = 0; i < lim && !found; i++) begin
            if (pred_used[i]) run = 0;
            else begin
              run++;
              if (run == r.run_length) begin
                found = 1;
                hit = i + 1 - r.run_length;
                for (int unsigned j = hit; j <= i; j++) pred_used[j] = 1'b1;
                pred_free = (pred_free - r.run_length) & 13'h1fff;
                o.success = 1'b1;
                o.result_frame = hit[11:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.free_frames = pred_free[12:0];
    return o;
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        outcome_t got;
        outcome_t want;
        got = '{rsp_ch.success, rsp_ch.result_frame, rsp_ch.free_frames};
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("tb: unexpected result %p", got);
        end else begin
          want = pending_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: result mismatch, expected %p, got %p", want, got);
          end
        end
      end
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Valid stays high from one accepted request into the next unless the sender idles.
  task automatic send_request(request_t r, bit typed, outcome_t want);
    outcome_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= r.command;
    req_ch.frame_index <= r.frame_index;
    req_ch.run_length <= r.run_length;
    do @(posedge clk); while (!req_ch.ready);
    pred = predict_request(r);
    if (typed && pred !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: table row disagrees, expected %p, predicted %p", want, pred);
    end
    pending_outcomes.push_back(typed ? want : pred);
  endtask

  // Drains, lets the block settle, then writes the frame limit.
  task automatic write_limit(logic [12:0] value);
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pred_limit = value;
  endtask

  function automatic request_t random_request(int unsigned lim);
    request_t r;
    int unsigned pick;
    r.frame_index = 12'($urandom_range(4095));
    r.run_length = 13'($urandom_range(8191));
    pick = $urandom_range(99);
    if (pick < 40) r.command = CMD_ALLOC;
    else if (pick < 75) begin
      r.command = CMD_FREE;
      if (lim != 0 && $urandom_range(9) < 8) r.frame_index = 12'($urandom_range(lim - 1));
    end else if (pick < 95) begin
      r.command = CMD_RUN;
      if ($urandom_range(9) < 8) r.run_length = 13'($urandom_range(1, 12));
    end else r.command = CMD_BAD;
    return r;
  endfunction

  function automatic row_t req_row(logic [1:0] c, logic [11:0] f, logic [12:0] n,
                                   bit typed, logic s, logic [11:0] rf, logic [12:0] ff);
    row_t w;
    w.is_cfg = 0;
    w.cfg_value = '0;
    w.req = '{c, f, n};
    w.typed = typed;
    w.want = '{s, rf, ff};
    return w;
  endfunction

  function automatic row_t cfg_row(logic [12:0] v);
    row_t w;
    w = req_row(CMD_ALLOC, 0, 0, 0, 0, 0, 0);
    w.is_cfg = 1;
    w.cfg_value = v;
    return w;
  endfunction

  // Long receiver hold-off while requests keep coming.
  task automatic hold_receiver();
    hold_off = 1'b1;
    for (int i = 0; i < 600; i++) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    int unsigned lim;
    request_t r;
    cycles = 0;
    mismatches = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_ALLOC;
    req_ch.frame_index = '0;
    req_ch.run_length = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    predict_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty map, extremes, every command and corner case.
    directed.push_back(req_row(CMD_ALLOC, 0, 0, 1, 0, 0, 0));
    directed.push_back(req_row(CMD_RUN, 0, 1, 1, 0, 0, 0));
    directed.push_back(req_row(CMD_FREE, 4095, 0, 1, 1, 0, 1));
    directed.push_back(req_row(CMD_FREE, 4095, 0, 1, 0, 0, 1));
    directed.push_back(req_row(CMD_FREE, 0, 0, 1, 1, 0, 2));
    directed.push_back(req_row(CMD_FREE, 1, 0, 1, 1, 0, 3));
    directed.push_back(req_row(CMD_FREE, 2, 0, 0, 0, 0, 0));
    directed.push_back(req_row(CMD_BAD, 4095, 8191, 1, 0, 0, 4));
    directed.push_back(req_row(CMD_RUN, 0, 0, 1, 0, 0, 4));
    directed.push_back(req_row(CMD_RUN, 0, 8191, 1, 0, 0, 4));
    directed.push_back(req_row(CMD_RUN, 0, 3, 1, 1, 0, 1));
    directed.push_back(req_row(CMD_ALLOC, 0, 0, 1, 1, 4095, 0));
    directed.push_back(req_row(CMD_ALLOC, 0, 0, 1, 0, 0, 0));
    directed.push_back(req_row(CMD_FREE, 2048, 0, 0, 0, 0, 0));
    directed.push_back(req_row(CMD_FREE, 100, 0, 0, 0, 0, 0));
    directed.push_back(cfg_row(8));
    directed.push_back(req_row(CMD_FREE, 100, 0, 1, 0, 0, 2));
    directed.push_back(req_row(CMD_FREE, 7, 0, 1, 1, 0, 3));
    directed.push_back(req_row(CMD_ALLOC, 0, 0, 1, 1, 7, 2));
    directed.push_back(req_row(CMD_RUN, 0, 9, 1, 0, 0, 2));
    directed.push_back(cfg_row(0));
    directed.push_back(req_row(CMD_ALLOC, 0, 0, 1, 0, 0, 2));
    directed.push_back(cfg_row(8191));
    directed.push_back(req_row(CMD_ALLOC, 0, 0, 0, 0, 0, 0));
    directed.push_back(req_row(CMD_RUN, 0, 4096, 0, 0, 0, 0));
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_limit(directed[i].cfg_value);
      else send_request(directed[i].req, directed[i].typed, directed[i].want);
    end

    // Random phases across idling mixes and limit settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      case (phase)
        0: write_limit(13'd4096);
        1: write_limit(13'd64);
        2: write_limit(13'd200);
        3: write_limit(13'd4096);
        4: write_limit(13'd1);
        default: write_limit(13'd130);
      endcase
      lim = pred_limit > NumFrames ? NumFrames : pred_limit;
      if (phase == 0) begin
        // Fill the receiver while requests keep coming.
        fork
          hold_receiver();
          for (int i = 0; i < 40; i++) begin
            r = random_request(lim);
            send_request(r, 0, '0);
          end
        join
      end
      for (int i = 0; i < 145; i++) begin
        r = random_request(lim);
        send_request(r, 0, '0);
      end
    end

    // Drain and report.
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bfa_pkg.sv
src/bfa_if.sv
src/bitmap_frame_allocator.sv
src/bfa_checker.sv
sim/tb.sv
